FILE: hw/rtl/tcb_pkg.sv
// Shared types, field widths and codes of the text cell buffer.
package tcb_pkg;

    localparam int DEF_GRID_COLS  = 80;
    localparam int DEF_GRID_ROWS  = 25;
    localparam int DEF_CELL_COUNT = 2000;
    localparam int DEF_COLOR_BITS = 4;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam int FUNC_W  = 3;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int ATTR_W  = 2;
    localparam int RUN_W   = 11;
    localparam int SHIFT_W = 5;
    localparam int OFF_W   = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUT_CHAR   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT_RUN    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SCROLL     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SET_CURSOR = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ_CELL  = 3'd5;

    localparam logic [ATTR_W-1:0] ATTR_NONE   = 2'd0;
    localparam logic [ATTR_W-1:0] ATTR_UNUSED = 2'd3;

    localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;

    typedef enum logic [3:0] {
        OP_PUT,
        OP_BKSP,
        OP_RUN,
        OP_SCROLL,
        OP_BLANK_ALL,
        OP_CLEAR,
        OP_SET_CURSOR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [OFF_W-1:0]   offset;
        logic [OFF_W-1:0]   shift_off;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [ATTR_W-1:0]  attr;
        logic [RUN_W-1:0]   run_len;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
        logic [CHAR_W-1:0]  cell_char;
        logic [COLOR_W-1:0] cell_color;
        logic [ATTR_W-1:0]  cell_attr;
    } res_t;

endpackage

FILE: hw/rtl/tcb_fifo.sv
// Small first-in first-out queue built from registers.
module tcb_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/tcb_front.sv
// Front end: accepts commands, clamps coordinates and classifies them.
module tcb_front import tcb_pkg::*; #(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  logic               push,
    output logic               full,
    input  logic [FUNC_W-1:0]  func,
    input  logic [COL_W-1:0]   col,
    input  logic [ROW_W-1:0]   row,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [COLOR_W-1:0] color,
    input  logic [ATTR_W-1:0]  attr,
    input  logic [RUN_W-1:0]   run_length,
    input  logic [SHIFT_W-1:0] shift_rows,
    input  logic               q_full,
    input  logic               init_busy,
    output logic               q_push,
    output cmd_t               q_data
);

    logic [COL_W-1:0] col_c;
    logic [ROW_W-1:0] row_c;
    op_t              op;

    assign full   = q_full || init_busy;
    assign q_push = push && !full;

    assign col_c = (int'(col) >= GRID_COLS) ? COL_W'(GRID_COLS - 1) : col;
    assign row_c = (int'(row) >= GRID_ROWS) ? ROW_W'(GRID_ROWS - 1) : row;

    always_comb
    begin
        unique case (func)
            FUNC_PUT_CHAR:   op = (char_code == BACKSPACE_CHAR) ? OP_BKSP : OP_PUT;
            FUNC_PUT_RUN:    op = OP_RUN;
            FUNC_SCROLL:
            begin
                if (int'(shift_rows) >= GRID_ROWS)
                begin
                    op = OP_BLANK_ALL;
                end
                else if (shift_rows == '0)
                begin
                    op = OP_NOP;
                end
                else
                begin
                    op = OP_SCROLL;
                end
            end
            FUNC_CLEAR:      op = OP_CLEAR;
            FUNC_SET_CURSOR: op = OP_SET_CURSOR;
            FUNC_READ_CELL:  op = OP_READ;
            default:         op = OP_NOP;
        endcase
    end

    always_comb
    begin
        q_data.op        = op;
        q_data.col       = col_c;
        q_data.row       = row_c;
        q_data.offset    = OFF_W'(OFF_W'(row_c) * OFF_W'(GRID_COLS) + OFF_W'(col_c));
        q_data.shift_off = OFF_W'(OFF_W'(shift_rows) * OFF_W'(GRID_COLS));
        q_data.ch        = char_code;
        q_data.color     = color;
        q_data.attr      = (attr == ATTR_UNUSED) ? ATTR_NONE : attr;
        q_data.run_len   = run_length;
    end

endmodule

FILE: hw/rtl/tcb_back.sv
// Back end: executes commands on the cell memory and keeps the cursor.
module tcb_back import tcb_pkg::*; #(
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int CELL_COUNT = DEF_CELL_COUNT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd_head,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res_data,
    output logic init_busy
);

    localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
    localparam int MEM_AW     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CELL_W     = CHAR_W + COLOR_BITS + ATTR_W;
    localparam int CCOL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int END_ROW    = CELL_COUNT / GRID_COLS;
    localparam int MAX_ROW    = (END_ROW > GRID_ROWS - 1) ? END_ROW : GRID_ROWS - 1;
    localparam int CROW_W     = (MAX_ROW > 0) ? $clog2(MAX_ROW + 1) : 1;
    localparam int LAST_OFF   = CELL_COUNT - 1;
    localparam int LAST_COL   = LAST_OFF % GRID_COLS;
    localparam int LAST_ROW   = LAST_OFF / GRID_COLS;

    typedef enum logic [2:0] {
        ST_BLANK,
        ST_IDLE,
        ST_EXEC,
        ST_RUN,
        ST_SCROLL,
        ST_READ
    } state_t;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CCOL_W-1:0] cur_col_reg, cur_col_next;
    logic [CROW_W-1:0] cur_row_reg, cur_row_next;
    logic [OFF_W-1:0]  cur_off_reg, cur_off_next;
    logic [OFF_W-1:0]  walk_off_reg, walk_off_next;
    logic [CCOL_W-1:0] walk_col_reg, walk_col_next;
    logic [CROW_W-1:0] walk_row_reg, walk_row_next;
    logic [OFF_W-1:0]  src_off_reg, src_off_next;
    logic [RUN_W-1:0]  count_reg, count_next;
    logic              reply_reg, reply_next;
    logic              pend_reg, pend_next;
    logic [OFF_W-1:0]  pend_dst_reg, pend_dst_next;
    logic              pend_ok_reg, pend_ok_next;
    logic              read_ok_reg, read_ok_next;

    logic              mem_we;
    logic [OFF_W-1:0]  mem_wofs;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [OFF_W-1:0]  mem_rofs;

    logic [CELL_W-1:0]  wcell;
    logic [CELL_W-1:0]  bkcell;
    logic [CELL_W-1:0]  blank;
    logic [OFF_W-1:0]   off_inc;
    logic [OFF_W-1:0]   off_dec;
    logic               src_ok;
    logic [CHAR_W-1:0]  out_char;
    logic [COLOR_W-1:0] out_color;
    logic [ATTR_W-1:0]  out_attr;

    assign wcell   = {cmd_reg.ch, COLOR_BITS'(cmd_reg.color), cmd_reg.attr};
    assign bkcell  = {BLANK_CHAR, COLOR_BITS'(cmd_reg.color), cmd_reg.attr};
    assign blank   = {BLANK_CHAR, COLOR_BITS'(0), ATTR_NONE};
    assign off_inc = cur_off_reg + OFF_W'(1);
    assign off_dec = cur_off_reg - OFF_W'(1);
    assign src_ok  = (src_off_reg < OFF_W'(GRID_CELLS)) && (src_off_reg < OFF_W'(CELL_COUNT));

    assign init_busy = (state_reg == ST_BLANK) && !reply_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        cur_off_next  = cur_off_reg;
        walk_off_next = walk_off_reg;
        walk_col_next = walk_col_reg;
        walk_row_next = walk_row_reg;
        src_off_next  = src_off_reg;
        count_next    = count_reg;
        reply_next    = reply_reg;
        pend_next     = pend_reg;
        pend_dst_next = pend_dst_reg;
        pend_ok_next  = pend_ok_reg;
        read_ok_next  = read_ok_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        mem_we        = 1'b0;
        mem_wofs      = walk_off_reg;
        mem_wdata     = blank;
        mem_re        = 1'b0;
        mem_rofs      = src_off_reg;
        out_char      = '0;
        out_color     = '0;
        out_attr      = '0;

        unique case (state_reg)
            ST_BLANK:
            begin
                mem_we        = 1'b1;
                mem_wofs      = walk_off_reg;
                mem_wdata     = blank;
                walk_off_next = walk_off_reg + OFF_W'(1);
                if (walk_off_reg == OFF_W'(LAST_OFF))
                begin
                    res_push   = reply_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_head;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (cmd_reg.op)
                    OP_PUT:
                    begin
                        mem_we    = (cur_off_reg < OFF_W'(CELL_COUNT));
                        mem_wofs  = cur_off_reg;
                        mem_wdata = wcell;
                        if (off_inc >= OFF_W'(CELL_COUNT))
                        begin
                            cur_col_next = CCOL_W'(LAST_COL);
                            cur_row_next = CROW_W'(LAST_ROW);
                            cur_off_next = OFF_W'(LAST_OFF);
                        end
                        else
                        begin
                            cur_off_next = off_inc;
                            if (int'(cur_col_reg) == GRID_COLS - 1)
                            begin
                                cur_col_next = '0;
                                cur_row_next = cur_row_reg + CROW_W'(1);
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + CCOL_W'(1);
                            end
                        end
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_BKSP:
                    begin
                        if (cur_off_reg != '0)
                        begin
                            mem_we    = (off_dec < OFF_W'(CELL_COUNT));
                            mem_wofs  = off_dec;
                            mem_wdata = bkcell;
                            if (off_dec >= OFF_W'(CELL_COUNT))
                            begin
                                cur_col_next = CCOL_W'(LAST_COL);
                                cur_row_next = CROW_W'(LAST_ROW);
                                cur_off_next = OFF_W'(LAST_OFF);
                            end
                            else
                            begin
                                cur_off_next = off_dec;
                                if (cur_col_reg == '0)
                                begin
                                    cur_col_next = CCOL_W'(GRID_COLS - 1);
                                    cur_row_next = cur_row_reg - CROW_W'(1);
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg - CCOL_W'(1);
                                end
                            end
                        end
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_RUN:
                    begin
                        walk_off_next = cmd_reg.offset;
                        walk_col_next = CCOL_W'(cmd_reg.col);
                        walk_row_next = CROW_W'(cmd_reg.row);
                        count_next    = cmd_reg.run_len;
                        state_next    = ST_RUN;
                    end
                    OP_SCROLL:
                    begin
                        walk_off_next = '0;
                        src_off_next  = cmd_reg.shift_off;
                        pend_next     = 1'b0;
                        state_next    = ST_SCROLL;
                    end
                    OP_BLANK_ALL:
                    begin
                        walk_off_next = '0;
                        reply_next    = 1'b1;
                        state_next    = ST_BLANK;
                    end
                    OP_CLEAR:
                    begin
                        walk_off_next = '0;
                        reply_next    = 1'b1;
                        cur_col_next  = '0;
                        cur_row_next  = '0;
                        cur_off_next  = '0;
                        state_next    = ST_BLANK;
                    end
                    OP_SET_CURSOR:
                    begin
                        cur_col_next = CCOL_W'(cmd_reg.col);
                        cur_row_next = CROW_W'(cmd_reg.row);
                        cur_off_next = cmd_reg.offset;
                        res_push     = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    OP_READ:
                    begin
                        mem_re       = (cmd_reg.offset < OFF_W'(CELL_COUNT));
                        mem_rofs     = cmd_reg.offset;
                        read_ok_next = (cmd_reg.offset < OFF_W'(CELL_COUNT));
                        state_next   = ST_READ;
                    end
                    OP_NOP:
                    begin
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RUN:
            begin
                if ((count_reg != '0) && (walk_off_reg < OFF_W'(CELL_COUNT)))
                begin
                    mem_we        = 1'b1;
                    mem_wofs      = walk_off_reg;
                    mem_wdata     = wcell;
                    walk_off_next = walk_off_reg + OFF_W'(1);
                    count_next    = count_reg - RUN_W'(1);
                    if (int'(walk_col_reg) == GRID_COLS - 1)
                    begin
                        walk_col_next = '0;
                        walk_row_next = walk_row_reg + CROW_W'(1);
                    end
                    else
                    begin
                        walk_col_next = walk_col_reg + CCOL_W'(1);
                    end
                end
                else
                begin
                    if (walk_off_reg >= OFF_W'(CELL_COUNT))
                    begin
                        cur_col_next = CCOL_W'(LAST_COL);
                        cur_row_next = CROW_W'(LAST_ROW);
                        cur_off_next = OFF_W'(LAST_OFF);
                    end
                    else
                    begin
                        cur_col_next = walk_col_reg;
                        cur_row_next = walk_row_reg;
                        cur_off_next = walk_off_reg;
                    end
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                if (pend_reg && (pend_dst_reg < OFF_W'(CELL_COUNT)))
                begin
                    mem_we    = 1'b1;
                    mem_wofs  = pend_dst_reg;
                    mem_wdata = pend_ok_reg ? rdata_reg : blank;
                end
                if (walk_off_reg < OFF_W'(GRID_CELLS))
                begin
                    mem_re        = src_ok;
                    mem_rofs      = src_off_reg;
                    pend_next     = 1'b1;
                    pend_dst_next = walk_off_reg;
                    pend_ok_next  = src_ok;
                    walk_off_next = walk_off_reg + OFF_W'(1);
                    src_off_next  = src_off_reg + OFF_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                if (read_ok_reg)
                begin
                    out_char  = rdata_reg[CELL_W-1 -: CHAR_W];
                    out_color = COLOR_W'(rdata_reg[ATTR_W +: COLOR_BITS]);
                    out_attr  = rdata_reg[ATTR_W-1:0];
                end
                else
                begin
                    out_char = BLANK_CHAR;
                end
                res_push   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_data.cursor_col = COL_W'(cur_col_next);
        res_data.cursor_row = ROW_W'(cur_row_next);
        res_data.cell_char  = out_char;
        res_data.cell_color = out_color;
        res_data.cell_attr  = out_attr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_BLANK;
            reply_reg    <= 1'b0;
            walk_off_reg <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            cur_off_reg  <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            reply_reg    <= reply_next;
            walk_off_reg <= walk_off_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            cur_off_reg  <= cur_off_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        walk_col_reg <= walk_col_next;
        walk_row_reg <= walk_row_next;
        src_off_reg  <= src_off_next;
        count_reg    <= count_next;
        pend_dst_reg <= pend_dst_next;
        pend_ok_reg  <= pend_ok_next;
        read_ok_reg  <= read_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wofs[MEM_AW-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_rofs[MEM_AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("Result pushed into a full result queue.");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_wofs < OFF_W'(CELL_COUNT)))
        else $error("Cell memory written outside the store.");

    a_cursor_sync: assert property (@(posedge clk) disable iff (!rst_n)
        cur_off_reg == OFF_W'(OFF_W'(cur_row_reg) * OFF_W'(GRID_COLS) + OFF_W'(cur_col_reg)))
        else $error("Cursor offset disagrees with cursor column and row.");

    a_init_hold: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !cmd_pop)
        else $error("Command taken during the clearing pass after reset.");
`endif

endmodule

FILE: hw/rtl/text_cell_buffer_with_cursor_unit.sv
// Top level of the text cell buffer with cursor.
// Commands enter through a queue-like port (push/full) and results leave through one
// (empty/pop); every command gives exactly one result, in order. A front end clamps
// coordinates and classifies each command into a two-entry command queue; the back end
// executes them one at a time on a single-write, single-read cell memory and delivers
// results into a two-entry result queue. Put char, backspace, set cursor and no-op
// commands give their result from the execute state and read cell from the read state;
// put run, scroll, clear and a scroll by the full height or more walk the memory through
// the one-cell-per-cycle memory write port. After reset the block clears the memory,
// during which full stays high.
module text_cell_buffer_with_cursor_unit import tcb_pkg::*; #(
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int CELL_COUNT = DEF_CELL_COUNT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [FUNC_W-1:0]  func,
    input  logic [COL_W-1:0]   col,
    input  logic [ROW_W-1:0]   row,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [COLOR_W-1:0] color,
    input  logic [ATTR_W-1:0]  attr,
    input  logic [RUN_W-1:0]   run_length,
    input  logic [SHIFT_W-1:0] shift_rows,
    output logic               empty,
    input  logic               pop,
    output logic [COL_W-1:0]   cursor_col,
    output logic [ROW_W-1:0]   cursor_row,
    output logic [CHAR_W-1:0]  cell_char,
    output logic [COLOR_W-1:0] cell_color,
    output logic [ATTR_W-1:0]  cell_attr
);

    logic q_push;
    cmd_t q_wdata;
    logic q_full;
    logic q_empty;
    logic q_pop;
    cmd_t q_rdata;
    logic init_busy;
    logic res_push;
    res_t res_wdata;
    logic res_full;
    res_t res_rdata;

    tcb_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .push       (push),
        .full       (full),
        .func       (func),
        .col        (col),
        .row        (row),
        .char_code  (char_code),
        .color      (color),
        .attr       (attr),
        .run_length (run_length),
        .shift_rows (shift_rows),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    tcb_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    tcb_back #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .CELL_COUNT (CELL_COUNT),
        .COLOR_BITS (COLOR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_head  (q_rdata),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata),
        .init_busy (init_busy)
    );

    tcb_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rdata),
        .empty   (empty)
    );

    assign cursor_col = res_rdata.cursor_col;
    assign cursor_row = res_rdata.cursor_row;
    assign cell_char  = res_rdata.cell_char;
    assign cell_color = res_rdata.cell_color;
    assign cell_attr  = res_rdata.cell_attr;

endmodule

FILE: verif/text_cell_buffer_with_cursor_unit_tb.sv
// Self-checking testbench that drives commands into the text cell buffer and checks every answer.
module text_cell_buffer_with_cursor_unit_tb import tcb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = DEF_GRID_COLS;
    localparam int ROWS  = DEF_GRID_ROWS;
    localparam int CELLS = DEF_CELL_COUNT;

    localparam logic [FUNC_W-1:0] FUNC_RESERVED_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [ATTR_W-1:0]  attr;
    } cell_t;

    localparam cell_t BLANK_CELL = '{ch: BLANK_CHAR, color: '0, attr: ATTR_NONE};

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] color;
        logic [ATTR_W-1:0]  attr;
        logic [RUN_W-1:0]   run_length;
        logic [SHIFT_W-1:0] shift_rows;
    } term_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [FUNC_W-1:0]  func = '0;
    logic [COL_W-1:0]   col = '0;
    logic [ROW_W-1:0]   row = '0;
    logic [CHAR_W-1:0]  char_code = '0;
    logic [COLOR_W-1:0] color = '0;
    logic [ATTR_W-1:0]  attr = '0;
    logic [RUN_W-1:0]   run_length = '0;
    logic [SHIFT_W-1:0] shift_rows = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
    logic [ATTR_W-1:0]  cell_attr;

    cell_t screen_cells [CELLS];
    int    pred_col;
    int    pred_row;
    res_t  pending_answers [$];
    int    fail_count = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    text_cell_buffer_with_cursor_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .col        (col),
        .row        (row),
        .char_code  (char_code),
        .color      (color),
        .attr       (attr),
        .run_length (run_length),
        .shift_rows (shift_rows),
        .empty      (empty),
        .pop        (pop),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .cell_attr  (cell_attr)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            screen_cells[i] = BLANK_CELL;
        end
    endfunction

    function automatic int clamp_col(int c);
        return (c >= COLS) ? COLS - 1 : c;
    endfunction

    function automatic int clamp_row(int r);
        return (r >= ROWS) ? ROWS - 1 : r;
    endfunction

    function automatic void place_cursor(int off);
        if (off >= CELLS)
        begin
            off = CELLS - 1;
        end
        pred_row = off / COLS;
        pred_col = off % COLS;
    endfunction

    function automatic void apply_to_screen(term_cmd_t c);
        cell_t wc;
        cell_t rc;
        int    off;
        int    amt;
        int    n;
        bit    is_read;
        res_t  ans;
        is_read  = 1'b0;
        rc       = '0;
        wc.ch    = c.char_code;
        wc.color = c.color;
        wc.attr  = (c.attr == ATTR_UNUSED) ? ATTR_NONE : c.attr;
        case (c.func)
            FUNC_PUT_CHAR:
            begin
                off = pred_row * COLS + pred_col;
                if (wc.ch == BACKSPACE_CHAR)
                begin
                    if (off > 0)
                    begin
                        off = off - 1;
                        wc.ch = BLANK_CHAR;
                        screen_cells[off] = wc;
                    end
                end
                else
                begin
                    screen_cells[off] = wc;
                    off = off + 1;
                end
                place_cursor(off);
            end
            FUNC_PUT_RUN:
            begin
                off = clamp_row(int'(c.row)) * COLS + clamp_col(int'(c.col));
                n = int'(c.run_length);
                for (int i = 0; i < n && off < CELLS; i++)
                begin
                    screen_cells[off] = wc;
                    off = off + 1;
                end
                place_cursor(off);
            end
            FUNC_SCROLL:
            begin
                amt = int'(c.shift_rows);
                if (amt >= ROWS)
                begin
                    blank_screen();
                end
                else if (amt > 0)
                begin
                    for (int i = 0; i < (ROWS - amt) * COLS; i++)
                    begin
                        screen_cells[i] = screen_cells[i + amt * COLS];
                    end
                    for (int i = (ROWS - amt) * COLS; i < CELLS; i++)
                    begin
                        screen_cells[i] = BLANK_CELL;
                    end
                end
            end
            FUNC_CLEAR:
            begin
                blank_screen();
                pred_col = 0;
                pred_row = 0;
            end
            FUNC_SET_CURSOR:
            begin
                pred_col = clamp_col(int'(c.col));
                pred_row = clamp_row(int'(c.row));
            end
            FUNC_READ_CELL:
            begin
                rc = screen_cells[clamp_row(int'(c.row)) * COLS + clamp_col(int'(c.col))];
                is_read = 1'b1;
            end
            default:
            begin
            end
        endcase
        ans.cursor_col = COL_W'(pred_col);
        ans.cursor_row = ROW_W'(pred_row);
        ans.cell_char  = is_read ? rc.ch : '0;
        ans.cell_color = is_read ? rc.color : '0;
        ans.cell_attr  = is_read ? rc.attr : '0;
        pending_answers.push_back(ans);
    endfunction

    function automatic term_cmd_t mk_cmd(logic [FUNC_W-1:0] f, int c, int r, int ch,
                                         int clr, int at, int len, int sh);
        term_cmd_t cmd;
        cmd.func       = f;
        cmd.col        = COL_W'(c);
        cmd.row        = ROW_W'(r);
        cmd.char_code  = CHAR_W'(ch);
        cmd.color      = COLOR_W'(clr);
        cmd.attr       = ATTR_W'(at);
        cmd.run_length = RUN_W'(len);
        cmd.shift_rows = SHIFT_W'(sh);
        return cmd;
    endfunction

    function automatic term_cmd_t rand_cmd(logic [FUNC_W-1:0] f);
        return mk_cmd(f, $urandom_range(127), $urandom_range(31), $urandom_range(255),
                      $urandom_range(15), $urandom_range(3), $urandom_range(2047),
                      $urandom_range(31));
    endfunction

    task automatic send_cmd(term_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        func       <= c.func;
        col        <= c.col;
        row        <= c.row;
        char_code  <= c.char_code;
        color      <= c.color;
        attr       <= c.attr;
        run_length <= c.run_length;
        shift_rows <= c.shift_rows;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        apply_to_screen(c);
    endtask

    task automatic wait_all_answered();
        push <= 1'b0;
        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic read_at(int c, int r);
        term_cmd_t cmd;
        cmd = rand_cmd(FUNC_READ_CELL);
        cmd.col = COL_W'(c);
        cmd.row = ROW_W'(r);
        send_cmd(cmd);
    endtask

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (pop && !empty)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (cursor_col !== want.cursor_col)
                begin
                    $error("cursor_col: expected %0d, actual %0d", want.cursor_col, cursor_col);
                    fail_count++;
                end
                if (cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row: expected %0d, actual %0d", want.cursor_row, cursor_row);
                    fail_count++;
                end
                if (cell_char !== want.cell_char)
                begin
                    $error("cell_char: expected %0d, actual %0d", want.cell_char, cell_char);
                    fail_count++;
                end
                if (cell_color !== want.cell_color)
                begin
                    $error("cell_color: expected %0d, actual %0d", want.cell_color, cell_color);
                    fail_count++;
                end
                if (cell_attr !== want.cell_attr)
                begin
                    $error("cell_attr: expected %0d, actual %0d", want.cell_attr, cell_attr);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_put_char();
        read_at(0, 0);
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 0, 0, int'(BACKSPACE_CHAR), 5, 1, 0, 0));
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 127, 31, 'h41, 15, 2, 2047, 31));
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 0, 0, 'hFF, 0, 3, 0, 0));
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 0, 0, int'(BACKSPACE_CHAR), 9, 1, 0, 0));
        read_at(1, 0);
        read_at(0, 0);
    endtask

    task automatic test_cursor_edges();
        send_cmd(mk_cmd(FUNC_SET_CURSOR, 127, 31, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 0, 0, 'h00, 3, 1, 0, 0));
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 0, 0, 'h7E, 12, 2, 0, 0));
        read_at(79, 24);
        send_cmd(mk_cmd(FUNC_SET_CURSOR, COLS - 1, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 0, 0, 'h5A, 7, 0, 0, 0));
    endtask

    task automatic test_put_run();
        send_cmd(mk_cmd(FUNC_PUT_RUN, 70, 24, 'h2A, 4, 1, 2047, 0));
        send_cmd(mk_cmd(FUNC_PUT_RUN, 5, 3, 'h2B, 4, 1, 0, 0));
        send_cmd(mk_cmd(FUNC_PUT_RUN, 0, 0, 'h23, 10, 2, 200, 0));
        read_at(127, 31);
    endtask

    task automatic test_scroll();
        send_cmd(mk_cmd(FUNC_SCROLL, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_SCROLL, 0, 0, 0, 0, 0, 0, 1));
        read_at(0, 0);
        read_at(79, 24);
        send_cmd(mk_cmd(FUNC_SCROLL, 0, 0, 0, 0, 0, 0, ROWS));
        send_cmd(mk_cmd(FUNC_SCROLL, 0, 0, 0, 0, 0, 0, 31));
    endtask

    task automatic test_clear_and_reserved();
        send_cmd(rand_cmd(FUNC_RESERVED_LO));
        send_cmd(rand_cmd(FUNC_RESERVED_HI));
        send_cmd(mk_cmd(FUNC_PUT_CHAR, 0, 0, 'h61, 1, 1, 0, 0));
        send_cmd(mk_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        read_at(10, 10);
    endtask

    task automatic test_random_traffic(int count);
        term_cmd_t cmd;
        int sent;
        int sel;
        int k;
        int start_off;
        int off;
        sent = 0;
        while (sent < count)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
            begin
                cmd = rand_cmd(FUNC_SET_CURSOR);
                if ($urandom_range(9) != 0)
                begin
                    cmd.col = COL_W'($urandom_range(COLS - 1));
                    cmd.row = ROW_W'($urandom_range(ROWS - 1));
                end
                send_cmd(cmd);
                start_off = pred_row * COLS + pred_col;
                k = $urandom_range(1, 8);
                for (int j = 0; j < k; j++)
                begin
                    cmd = rand_cmd(FUNC_PUT_CHAR);
                    if ($urandom_range(9) == 0)
                    begin
                        cmd.char_code = BACKSPACE_CHAR;
                    end
                    send_cmd(cmd);
                end
                for (int j = 0; j < k; j++)
                begin
                    off = (start_off + j < CELLS) ? start_off + j : CELLS - 1;
                    read_at(off % COLS, off / COLS);
                end
                sent += 2 * k + 1;
            end
            else if (sel < 60)
            begin
                cmd = rand_cmd(FUNC_PUT_RUN);
                if ($urandom_range(9) != 0)
                begin
                    cmd.run_length = RUN_W'($urandom_range(40));
                end
                send_cmd(cmd);
                read_at(int'(cmd.col), int'(cmd.row));
                sent += 2;
            end
            else if (sel < 68)
            begin
                send_cmd(rand_cmd(FUNC_SCROLL));
                read_at($urandom_range(127), $urandom_range(31));
                sent += 2;
            end
            else if (sel < 70)
            begin
                send_cmd(rand_cmd(FUNC_CLEAR));
                sent += 1;
            end
            else if (sel < 73)
            begin
                send_cmd(rand_cmd($urandom_range(1) ? FUNC_RESERVED_HI : FUNC_RESERVED_LO));
                sent += 1;
            end
            else if (sel < 83)
            begin
                send_cmd(rand_cmd(FUNC_SET_CURSOR));
                sent += 1;
            end
            else
            begin
                send_cmd(rand_cmd(FUNC_READ_CELL));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        blank_screen();
        pred_col = 0;
        pred_row = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 87;
        test_put_char();
        test_cursor_edges();
        test_put_run();
        test_scroll();
        test_clear_and_reserved();
        test_random_traffic(150);
        wait_all_answered();

        send_idle_pct = 87;
        recv_idle_pct = 25;
        test_random_traffic(150);
        wait_all_answered();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(150);
        wait_all_answered();

        repeat (100) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
